[hdl/rrns_pkg.sv]
// Package for the range removal block: sequencer states, bitmap word geometry
// and the bit search and mask helpers shared by the top level.
// No dependencies.
package rrns_pkg;

    localparam int SLOT_W    = 11;
    localparam int WORD_BITS = 32;
    localparam int BIT_SEL_W = 5;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [SLOT_W-1:0]    t_slot;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LSCAN,
        ST_RSCAN,
        ST_CLEAR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                 found;
        logic [BIT_SEL_W-1:0] pos;
    } t_bit_hit;

    // Highest set bit of a word.
    function automatic t_bit_hit f_find_high(input t_word w);
        t_bit_hit h;
        h.found = 1'b0;
        h.pos   = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (w[i]) begin
                h.found = 1'b1;
                h.pos   = BIT_SEL_W'(i);
            end
        end
        return h;
    endfunction

    // Lowest set bit of a word.
    function automatic t_bit_hit f_find_low(input t_word w);
        t_bit_hit h;
        h.found = 1'b0;
        h.pos   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                h.found = 1'b1;
                h.pos   = BIT_SEL_W'(i);
            end
        end
        return h;
    endfunction

    // Ones at bit positions at or above lo.
    function automatic t_word f_mask_ge(input logic [BIT_SEL_W-1:0] lo);
        return {WORD_BITS{1'b1}} << lo;
    endfunction

    // Ones at bit positions at or below hi.
    function automatic t_word f_mask_le(input logic [BIT_SEL_W-1:0] hi);
        return {WORD_BITS{1'b1}} >> (BIT_SEL_W'(WORD_BITS - 1) - hi);
    endfunction

endpackage

[hdl/range_remove_nearest_survivor_top.sv]
// Top level of the range removal block: sequencer, alive bitmap and result register.
// Depends on rrns_pkg and rrns_ram.
//
// Usage: slots 1..slot_count are kept in an alive bitmap, all alive after reset.
// Each input transaction (i_valid/o_ready) carries a range [first_slot, last_slot].
// The block returns, on the output channel (o_valid/i_ready), the nearest alive
// slot below the range and the nearest alive slot above it, each with a found
// flag, and then marks the whole range dead. An invalid range (first of zero,
// first above last, or last above the slot count) gives range_error with all
// other fields zero and changes nothing.
// Flow: one transaction at a time. A valid range runs a left search, a right search
// (skipped when last is the slot count) and a clearing sweep, each visiting bitmap words
// in turn through the single RAM read port. An invalid range skips all three and goes
// straight to the result. Input is ready again once the result is loaded.
// Reset makes every slot alive and sets the slot count to 1024; a write of the
// slot count does the same revival. Both act through per-word valid bits, so
// there is no clearing pass. A result waits in the output register while the
// receiver stalls; the next input is still accepted and processed, and only
// its own result waits for the output register to empty.
module range_remove_nearest_survivor_top
    import rrns_pkg::*;
#(
    parameter int MAX_SLOTS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input channel.
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [SLOT_W-1:0] i_first_slot,
    input  logic [SLOT_W-1:0] i_last_slot,
    // Output channel.
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_has_left,
    output logic [SLOT_W-1:0] o_left_slot,
    output logic              o_has_right,
    output logic [SLOT_W-1:0] o_right_slot,
    output logic              o_range_error,
    // Slot count register.
    input  logic              i_cfg_wr_en,
    input  logic [SLOT_W-1:0] i_cfg_wr_data
);

    // Slot numbers are 11 bits, so no slot above 2047 is ever addressed.
    localparam int MAXC   = (MAX_SLOTS > 2047) ? 2047 : MAX_SLOTS;
    localparam int NWORDS = MAXC / WORD_BITS + 1;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam logic [SLOT_W-1:0] MAXC_S      = SLOT_W'(MAXC);
    localparam logic [SLOT_W-1:0] RESET_COUNT = SLOT_W'(1024);

    // Control state.
    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_slot_count, n_slot_count;
    logic [NWORDS-1:0]   r_word_valid, n_word_valid;
    logic                r_pend, n_pend;
    logic                r_o_valid, n_o_valid;

    // Working registers.
    logic [SLOT_W-1:0]   r_first, n_first;
    logic [SLOT_W-1:0]   r_last, n_last;
    logic [AW-1:0]       r_raddr, n_raddr;
    logic [AW-1:0]       r_daddr, n_daddr;
    logic                r_rvalid, n_rvalid;
    logic                r_has_left, n_has_left;
    logic [SLOT_W-1:0]   r_left, n_left;
    logic                r_has_right, n_has_right;
    logic [SLOT_W-1:0]   r_right, n_right;
    logic                r_err, n_err;

    // Output register.
    logic                r_o_has_left, n_o_has_left;
    logic [SLOT_W-1:0]   r_o_left, n_o_left;
    logic                r_o_has_right, n_o_has_right;
    logic [SLOT_W-1:0]   r_o_right, n_o_right;
    logic                r_o_err, n_o_err;

    // Bitmap RAM port signals.
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    t_word               ram_wdata;
    t_word               ram_rdata;

    // Derived values.
    logic [SLOT_W-1:0]   w_count;
    t_word               w_word;
    logic [SLOT_W-1:0]   w_s0;
    logic [AW-1:0]       w_s0_word;
    logic [SLOT_W:0]     w_t0;
    logic [AW-1:0]       w_t0_word;
    logic [AW-1:0]       w_cw;
    logic [AW-1:0]       w_fw;
    logic [AW-1:0]       w_lw;
    logic                w_accept;
    logic                w_in_err;
    logic                w_left_done;
    logic                w_right_done;
    t_word               w_mask;
    t_bit_hit            w_hit;
    logic [BIT_SEL_W-1:0] w_lo;
    logic [BIT_SEL_W-1:0] w_hi;

    rrns_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_raddr),
        .o_rdata (ram_rdata)
    );

    // A slot count above the bitmap size saturates.
    assign w_count = (r_slot_count > MAXC_S) ? MAXC_S : r_slot_count;

    // A word never written since the last revival reads as all alive.
    assign w_word = r_rvalid ? ram_rdata : {WORD_BITS{1'b1}};

    assign w_s0      = r_first - SLOT_W'(1);
    assign w_s0_word = AW'(w_s0 >> BIT_SEL_W);
    assign w_t0      = {1'b0, r_last} + (SLOT_W + 1)'(1);
    assign w_t0_word = AW'(w_t0 >> BIT_SEL_W);
    assign w_cw      = AW'(w_count >> BIT_SEL_W);
    assign w_fw      = AW'(r_first >> BIT_SEL_W);
    assign w_lw      = AW'(r_last >> BIT_SEL_W);

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_in_err = (i_first_slot == '0) || (i_first_slot > i_last_slot)
                      || (i_last_slot > w_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_slot_count <= RESET_COUNT;
            r_word_valid <= '0;
            r_pend       <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot_count <= n_slot_count;
            r_word_valid <= n_word_valid;
            r_pend       <= n_pend;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first       <= n_first;
        r_last        <= n_last;
        r_raddr       <= n_raddr;
        r_daddr       <= n_daddr;
        r_rvalid      <= n_rvalid;
        r_has_left    <= n_has_left;
        r_left        <= n_left;
        r_has_right   <= n_has_right;
        r_right       <= n_right;
        r_err         <= n_err;
        r_o_has_left  <= n_o_has_left;
        r_o_left      <= n_o_left;
        r_o_has_right <= n_o_has_right;
        r_o_right     <= n_o_right;
        r_o_err       <= n_o_err;
    end

    always_comb begin
        n_state       = r_state;
        n_slot_count  = r_slot_count;
        n_word_valid  = r_word_valid;
        n_pend        = r_pend;
        n_o_valid     = r_o_valid;
        n_first       = r_first;
        n_last        = r_last;
        n_raddr       = r_raddr;
        n_daddr       = r_raddr;
        n_rvalid      = r_word_valid[r_raddr];
        n_has_left    = r_has_left;
        n_left        = r_left;
        n_has_right   = r_has_right;
        n_right       = r_right;
        n_err         = r_err;
        n_o_has_left  = r_o_has_left;
        n_o_left      = r_o_left;
        n_o_has_right = r_o_has_right;
        n_o_right     = r_o_right;
        n_o_err       = r_o_err;
        ram_we        = 1'b0;
        ram_waddr     = r_daddr;
        ram_wdata     = w_word;
        w_left_done   = 1'b0;
        w_right_done  = 1'b0;
        w_mask        = {WORD_BITS{1'b1}};
        w_hit         = '0;
        w_lo          = '0;
        w_hi          = BIT_SEL_W'(WORD_BITS - 1);

        // The receiver takes the waiting result.
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_first     = i_first_slot;
                    n_last      = i_last_slot;
                    n_has_left  = 1'b0;
                    n_left      = '0;
                    n_has_right = 1'b0;
                    n_right     = '0;
                    n_err       = w_in_err;
                    n_pend      = 1'b0;
                    n_raddr     = AW'((i_first_slot - SLOT_W'(1)) >> BIT_SEL_W);
                    n_state     = w_in_err ? ST_DONE : ST_LSCAN;
                end
            end

            // Walk down from the word holding first-1; slot 0 never counts.
            ST_LSCAN: begin
                n_pend  = 1'b1;
                n_raddr = (r_raddr != '0) ? r_raddr - AW'(1) : r_raddr;
                if (r_pend) begin
                    if (r_daddr == w_s0_word) begin
                        w_mask = w_mask & f_mask_le(w_s0[BIT_SEL_W-1:0]);
                    end
                    if (r_daddr == '0) begin
                        w_mask[0] = 1'b0;
                    end
                    w_hit = f_find_high(w_word & w_mask);
                    if (w_hit.found) begin
                        n_has_left  = 1'b1;
                        n_left      = SLOT_W'({r_daddr, w_hit.pos});
                        w_left_done = 1'b1;
                    end else if (r_daddr == '0) begin
                        w_left_done = 1'b1;
                    end
                end
                if (w_left_done) begin
                    n_pend = 1'b0;
                    // With last at the slot count there is nothing to search above.
                    if (w_t0 > {1'b0, w_count}) begin
                        n_raddr = w_fw;
                        n_state = ST_CLEAR;
                    end else begin
                        n_raddr = w_t0_word;
                        n_state = ST_RSCAN;
                    end
                end
            end

            // Walk up from the word holding last+1 to the word holding the count.
            ST_RSCAN: begin
                n_pend  = 1'b1;
                n_raddr = (r_raddr != w_cw) ? r_raddr + AW'(1) : r_raddr;
                if (r_pend) begin
                    if (r_daddr == w_t0_word) begin
                        w_mask = w_mask & f_mask_ge(w_t0[BIT_SEL_W-1:0]);
                    end
                    if (r_daddr == w_cw) begin
                        w_mask = w_mask & f_mask_le(w_count[BIT_SEL_W-1:0]);
                    end
                    w_hit = f_find_low(w_word & w_mask);
                    if (w_hit.found) begin
                        n_has_right  = 1'b1;
                        n_right      = SLOT_W'({r_daddr, w_hit.pos});
                        w_right_done = 1'b1;
                    end else if (r_daddr == w_cw) begin
                        w_right_done = 1'b1;
                    end
                end
                if (w_right_done) begin
                    n_pend  = 1'b0;
                    n_raddr = w_fw;
                    n_state = ST_CLEAR;
                end
            end

            // Read-modify-write sweep; the write of one word overlaps the read of
            // the next, so the two never touch the same entry in a cycle that counts.
            ST_CLEAR: begin
                n_pend  = 1'b1;
                n_raddr = (r_raddr != w_lw) ? r_raddr + AW'(1) : r_raddr;
                if (r_pend) begin
                    if (r_daddr == w_fw) begin
                        w_lo = r_first[BIT_SEL_W-1:0];
                    end
                    if (r_daddr == w_lw) begin
                        w_hi = r_last[BIT_SEL_W-1:0];
                    end
                    w_mask                = f_mask_ge(w_lo) & f_mask_le(w_hi);
                    ram_we                = 1'b1;
                    ram_waddr             = r_daddr;
                    ram_wdata             = w_word & ~w_mask;
                    n_word_valid[r_daddr] = 1'b1;
                    if (r_daddr == w_lw) begin
                        n_pend  = 1'b0;
                        n_state = ST_DONE;
                    end
                end
            end

            ST_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid     = 1'b1;
                    n_o_has_left  = r_has_left;
                    n_o_left      = r_left;
                    n_o_has_right = r_has_right;
                    n_o_right     = r_right;
                    n_o_err       = r_err;
                    n_state       = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
                n_pend  = 1'b0;
            end
        endcase

        // A new slot count revives every slot.
        if (i_cfg_wr_en) begin
            n_slot_count = i_cfg_wr_data;
            n_word_valid = '0;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_has_left    = r_o_has_left;
    assign o_left_slot   = r_o_left;
    assign o_has_right   = r_o_has_right;
    assign o_right_slot  = r_o_right;
    assign o_range_error = r_o_err;

endmodule

[hdl/rrns_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module rrns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 33
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
